// File: rtl/fbpa_pkg.sv
// Package for the fixed block pool allocator: sizes, register indexes,
// status codes and the request, response and shared-unit types.
// No dependencies; every other file of the block but fbpa_ram imports it.
package fbpa_pkg;

  // Pool geometry and address space.
  localparam int NUM_BLOCKS = 1024;
  localparam int ADDR_BITS  = 48;

  // Field widths of the request and response.
  localparam int FIELD_AW = 48;
  localparam int SIZE_W   = 32;
  localparam int ALIGN_W  = 13;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;

  // Free list: link memory address and an index wide enough for the null code.
  localparam int LINK_AW = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
  localparam int IDX_W   = $clog2(NUM_BLOCKS + 1);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(NUM_BLOCKS);

  // Shared adder width: base plus index times block size, with a carry bit.
  localparam int PROD_W  = SIZE_W + LINK_AW;
  localparam int ACC_W   = ((PROD_W > FIELD_AW) ? PROD_W : FIELD_AW) + 1;
  localparam int SHIFT_W = (LINK_AW > 1) ? $clog2(LINK_AW) : 1;

  // Granted addresses wrap at the address space, then fit the field.
  localparam int GRANT_BITS = (ADDR_BITS < FIELD_AW) ? ADDR_BITS : FIELD_AW;
  localparam logic [FIELD_AW-1:0] GRANT_MASK = {FIELD_AW{1'b1}} >> (FIELD_AW - GRANT_BITS);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_ALIGNMENT = 2'd3;

  // Register values after reset.
  localparam logic [FIELD_AW-1:0] POOL_BASE_RST      = '0;
  localparam logic [SIZE_W-1:0]   BLOCK_BYTES_RST    = 32'd64;
  localparam logic [COUNT_W-1:0]  BLOCKS_IN_USE_RST  = 11'd1024;
  localparam logic [ALIGN_W-1:0]  SIZE_ALIGNMENT_RST = 13'd64;

  // Commands and status codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WRONG_SIZE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNED  = 3'd4;

  typedef struct packed {
    logic                command;
    logic [SIZE_W-1:0]   request_size;
    logic [ALIGN_W-1:0]  alignment;
    logic [FIELD_AW-1:0] block_address;
  } fbpa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_AW-1:0] address;
    logic [SIZE_W-1:0]   granted_size;
  } fbpa_rsp_t;

  // Operands and result of the shared add/subtract unit.
  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
  } fbpa_alu_op_t;

  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic             borrow;
  } fbpa_alu_res_t;

endpackage

// File: rtl/fbpa_req_if.sv
// Request channel of the allocator: valid, ready and the request payload.
// Depends on fbpa_pkg.
interface fbpa_req_if;
  import fbpa_pkg::*;

  logic      valid;
  logic      ready;
  fbpa_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/fbpa_rsp_if.sv
// Response channel of the allocator: valid, ready and the response payload.
// Depends on fbpa_pkg.
interface fbpa_rsp_if;
  import fbpa_pkg::*;

  logic      valid;
  logic      ready;
  fbpa_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/fbpa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fbpa_shift_alu.sv
// Shared add/subtract unit of the allocator sequencer, with borrow out.
// Depends on fbpa_pkg for the operand and result types.
module fbpa_shift_alu (
  input  fbpa_pkg::fbpa_alu_op_t  op,
  output fbpa_pkg::fbpa_alu_res_t res
);
  import fbpa_pkg::*;

  logic [ACC_W:0] wide;

  // One wide adder; the top bit of a subtraction is the borrow.
  always_comb begin
    if (op.sub) begin
      wide = {1'b0, op.a} - {1'b0, op.b};
    end else begin
      wide = {1'b0, op.a} + {1'b0, op.b};
    end
    res.sum    = wide[ACC_W-1:0];
    res.borrow = op.sub & wide[ACC_W];
  end

endmodule

// File: rtl/fixed_block_pool_allocator_core.sv
// Fixed block pool allocator: free list of block indices in a link RAM.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if, fbpa_ram and fbpa_shift_alu.
//
//   channel | direction | handshake     | payload
//   --------+-----------+---------------+----------------------------------------------
//   cfg     | in        | cfg_we        | cfg_index, cfg_data
//   req     | in        | valid / ready | command, request_size, alignment, block_address
//   rsp     | out       | valid / ready | status, address, granted_size
//
// An allocate runs the shift-and-add multiply and a free runs it and then the restoring
// divide, one bit a cycle through the shared adder, LINK_AW steps each; the next request
// is taken in the cycle after the response moves to the output register. A wrong size
// or an empty pool answers from the check, and a free outside the pool from a range check.
// After reset, and after every write of blocks_in_use, a pass over all NUM_BLOCKS entries
// rebuilds the link RAM; no request is taken meanwhile.
// A response waiting on rsp does not stop the next request from being accepted.
module fixed_block_pool_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
  fbpa_req_if.sink                      req,
  fbpa_rsp_if.source                    rsp
);
  import fbpa_pkg::*;

  typedef enum logic [8:0] {
    S_FILL     = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_CHECK    = 9'b000000100,
    S_MUL      = 9'b000001000,
    S_RANGE_HI = 9'b000010000,
    S_RANGE_LO = 9'b000100000,
    S_DIV      = 9'b001000000,
    S_LINK     = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [FIELD_AW-1:0] pool_base;
  logic [SIZE_W-1:0]   block_bytes;
  logic [COUNT_W-1:0]  blocks_in_use;
  logic [ALIGN_W-1:0]  size_alignment;

  // Sequencer registers.
  logic [IDX_W-1:0]   head;
  logic [LINK_AW-1:0] fill_cnt;
  fbpa_req_t          req_q;
  logic [ACC_W-1:0]   acc;
  logic [LINK_AW-1:0] mul_op;
  logic [LINK_AW-1:0] quot;
  logic [SHIFT_W-1:0] step;
  fbpa_rsp_t          res_q;
  logic               out_valid;
  fbpa_rsp_t          out_data;

  // Derived values.
  logic [IDX_W-1:0]    count;
  logic [LINK_AW-1:0]  last_idx;
  logic [ALIGN_W-1:0]  round_m1;
  logic [SIZE_W:0]     rounded;
  logic                alloc_size_ok;
  logic [ALIGN_W-1:0]  align_m1;
  logic [FIELD_AW-1:0] grant_addr;
  logic                misaligned;
  logic [ACC_W-1:0]    shifted_bb;
  logic [IDX_W-1:0]    fill_succ;
  logic [IDX_W-1:0]    fill_val;
  logic [LINK_AW-1:0]  free_idx;
  logic                is_alloc;
  logic                rebuild;
  logic                out_load;

  // Link RAM ports.
  logic               ram_we;
  logic [LINK_AW-1:0] ram_waddr;
  logic [IDX_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]   ram_rdata;

  fbpa_alu_op_t  alu_op;
  fbpa_alu_res_t alu_res;

  function automatic fbpa_rsp_t fail_rsp(input logic [STATUS_W-1:0] code);
    fbpa_rsp_t r;
    r.status       = code;
    r.address      = '0;
    r.granted_size = '0;
    return r;
  endfunction

  assign is_alloc  = (req_q.command == CMD_ALLOC);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // A write of the block count restarts the rebuild pass.
  assign rebuild  = cfg_we && (cfg_index == REG_BLOCKS_IN_USE);

  // The finished response moves to the output register once that is free.
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  // Effective block count: zero counts as one, large values are capped.
  always_comb begin
    if (blocks_in_use == '0) begin
      count = IDX_W'(1);
    end else if (32'(blocks_in_use) > 32'(NUM_BLOCKS)) begin
      count = NIL;
    end else begin
      count = IDX_W'(blocks_in_use);
    end
  end

  assign last_idx = LINK_AW'(count - IDX_W'(1));

  // Size rounding and alignment tests.
  assign round_m1      = (size_alignment == '0) ? '0 : size_alignment - ALIGN_W'(1);
  assign rounded       = ({1'b0, req_q.request_size} + (SIZE_W+1)'(round_m1))
                         & ~((SIZE_W+1)'(round_m1));
  assign alloc_size_ok = (rounded == {1'b0, block_bytes});
  assign align_m1      = (req_q.alignment == '0) ? '0 : req_q.alignment - ALIGN_W'(1);
  assign grant_addr    = acc[FIELD_AW-1:0] & GRANT_MASK;
  assign misaligned    = |(grant_addr[ALIGN_W-1:0] & align_m1);
  assign shifted_bb    = ACC_W'(block_bytes) << step;

  // Initial free list entry for the rebuild pass.
  assign fill_succ = IDX_W'(fill_cnt) + IDX_W'(1);
  assign fill_val  = (fill_succ < count) ? fill_succ : NIL;

  // Index of the freed block; a zero block size always frees block zero.
  always_comb begin
    if (block_bytes == '0) begin
      free_idx = '0;
    end else if (IDX_W'(quot) >= count) begin
      free_idx = last_idx;
    end else begin
      free_idx = quot;
    end
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_op.a   = acc;
    alu_op.b   = '0;
    alu_op.sub = 1'b0;
    unique case (state)
      S_MUL: begin
        alu_op.b = mul_op[step] ? shifted_bb : '0;
      end
      S_RANGE_HI: begin
        alu_op.b   = ACC_W'(req_q.block_address);
        alu_op.sub = 1'b1;
      end
      S_RANGE_LO: begin
        alu_op.a   = ACC_W'(req_q.block_address);
        alu_op.b   = ACC_W'(pool_base);
        alu_op.sub = 1'b1;
      end
      S_DIV: begin
        alu_op.b   = shifted_bb;
        alu_op.sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  fbpa_shift_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  // Link RAM writes: the rebuild pass, or a push on a successful free.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_cnt;
    ram_wdata = fill_val;
    if (state == S_FILL) begin
      ram_we = 1'b1;
    end else if ((state == S_LINK) && !is_alloc) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx;
      ram_wdata = head;
    end
  end

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head[LINK_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_FILL;
      fill_cnt       <= '0;
      head           <= '0;
      out_valid      <= 1'b0;
      pool_base      <= POOL_BASE_RST;
      block_bytes    <= BLOCK_BYTES_RST;
      blocks_in_use  <= BLOCKS_IN_USE_RST;
      size_alignment <= SIZE_ALIGNMENT_RST;
    end else begin
      // Output register: loaded with a finished response, cleared when taken.
      if (out_load) begin
        out_data  <= res_q;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (rebuild) begin
        state    <= S_FILL;
        fill_cnt <= '0;
        head     <= '0;
      end else begin
        unique case (state)
          S_FILL: begin
            fill_cnt <= fill_cnt + LINK_AW'(1);
            if (fill_cnt == LINK_AW'(NUM_BLOCKS - 1)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (req.valid) begin
              req_q <= req.data;
              state <= S_CHECK;
            end
          end
          S_CHECK: begin
            acc  <= ACC_W'(pool_base);
            step <= '0;
            if (is_alloc) begin
              if (!alloc_size_ok) begin
                res_q <= fail_rsp(ST_WRONG_SIZE);
                state <= S_DONE;
              end else if (head == NIL) begin
                res_q <= fail_rsp(ST_EMPTY);
                state <= S_DONE;
              end else begin
                mul_op <= head[LINK_AW-1:0];
                state  <= S_MUL;
              end
            end else begin
              if (req_q.request_size != block_bytes) begin
                res_q <= fail_rsp(ST_WRONG_SIZE);
                state <= S_DONE;
              end else begin
                mul_op <= last_idx;
                state  <= S_MUL;
              end
            end
          end
          // Shift-and-add multiply, one multiplier bit a cycle.
          S_MUL: begin
            acc  <= alu_res.sum;
            step <= step + SHIFT_W'(1);
            if (step == SHIFT_W'(LINK_AW - 1)) begin
              state <= is_alloc ? S_LINK : S_RANGE_HI;
            end
          end
          // The accumulator holds the address of the last block here.
          S_RANGE_HI: begin
            if (alu_res.borrow) begin
              res_q <= fail_rsp(ST_NOT_OWNED);
              state <= S_DONE;
            end else begin
              state <= S_RANGE_LO;
            end
          end
          S_RANGE_LO: begin
            if (alu_res.borrow) begin
              res_q <= fail_rsp(ST_NOT_OWNED);
              state <= S_DONE;
            end else begin
              acc   <= alu_res.sum;
              quot  <= '0;
              step  <= SHIFT_W'(LINK_AW - 1);
              state <= S_DIV;
            end
          end
          // Restoring divide of the offset, most significant quotient bit first.
          S_DIV: begin
            if (!alu_res.borrow) begin
              acc        <= alu_res.sum;
              quot[step] <= 1'b1;
            end
            if (step == '0) begin
              state <= S_LINK;
            end else begin
              step <= step - SHIFT_W'(1);
            end
          end
          // Pop the head on a successful allocate or push the freed index.
          S_LINK: begin
            state <= S_DONE;
            if (is_alloc) begin
              if (misaligned) begin
                res_q <= fail_rsp(ST_MISALIGNED);
              end else begin
                head               <= ram_rdata;
                res_q.status       <= ST_OK;
                res_q.address      <= grant_addr;
                res_q.granted_size <= block_bytes;
              end
            end else begin
              head  <= IDX_W'(free_idx);
              res_q <= fail_rsp(ST_OK);
            end
          end
          S_DONE: begin
            if (out_load) begin
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_FILL;
          end
        endcase
      end

      // Register writes; a new block count rebuilds the free list.
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POOL_BASE:      pool_base      <= cfg_data[FIELD_AW-1:0];
          REG_BLOCK_BYTES:    block_bytes    <= cfg_data[SIZE_W-1:0];
          REG_BLOCKS_IN_USE:  blocks_in_use  <= cfg_data[COUNT_W-1:0];
          REG_SIZE_ALIGNMENT: size_alignment <= cfg_data[ALIGN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/fbpa_checker.sv
// Port-level checks for the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_core.
module fbpa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [fbpa_pkg::STATUS_W-1:0] rsp_status,
  input logic [fbpa_pkg::FIELD_AW-1:0] rsp_address,
  input logic [fbpa_pkg::SIZE_W-1:0]   rsp_granted_size
);
  import fbpa_pkg::*;

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_address) && $stable(rsp_granted_size))
    else $error("response changed while stalled");

  // A failed request grants neither an address nor a size.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |-> (rsp_address == '0) && (rsp_granted_size == '0))
    else $error("failed request carries an address or size");

  // The block works on one request at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is in work");

  // After reset nothing is offered and the free list is being rebuilt.
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_ready)
    else $error("block active straight after reset");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.data.status),
  .rsp_address      (rsp.data.address),
  .rsp_granted_size (rsp.data.granted_size)
);

// File: bench/fixed_block_pool_allocator_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for fixed_block_pool_allocator_core: allocate and free requests
// against a free-list predictor, with random idling, back-pressure and pool settings.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if and the core itself.
module fixed_block_pool_allocator_core_test;
  import fbpa_pkg::*;

  // Quiet time before a register write and at the end.
  localparam int SETTLE_CYCLES = 64;
  localparam logic [63:0] WRAP_MASK = (64'd1 << ADDR_BITS) - 64'd1;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fbpa_req_if req_ch ();
  fbpa_rsp_if rsp_ch ();

  fixed_block_pool_allocator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Predicted pool settings and free list.
  logic [FIELD_AW-1:0] pool_base_q;
  logic [SIZE_W-1:0]   block_bytes_q;
  logic [COUNT_W-1:0]  count_q;
  logic [ALIGN_W-1:0]  round_q;
  logic [IDX_W-1:0]    next_free [NUM_BLOCKS];
  logic [IDX_W-1:0]    free_top;

  fbpa_rsp_t           pending_replies [$];
  logic [FIELD_AW-1:0] held_blocks [$];
  int unsigned         error_count;
  int unsigned         burst_left;
  bit                  steady_sender;
  int unsigned         rsp_hold;

  // Block count as the pool sees it: zero means one, anything above the pool size is capped.
  function automatic int unsigned managed_blocks();
    int unsigned c;
    c = count_q;
    if (c == 0) c = 1;
    if (c > NUM_BLOCKS) c = NUM_BLOCKS;
    return c;
  endfunction

  // Every managed block is free again, in ascending order with block 0 at the head.
  function automatic void reset_free_list();
    int unsigned c;
    c = managed_blocks();
    for (int i = 0; i < NUM_BLOCKS; i++)
      next_free[i] = (i + 1 < c) ? IDX_W'(i + 1) : NIL;
    free_top = '0;
  endfunction

  // Works out the response to one request and updates the predicted free list.
  function automatic fbpa_rsp_t serve_request(input fbpa_req_t item);
    fbpa_rsp_t   reply;
    logic [63:0] step;
    logic [63:0] rounded;
    logic [63:0] need;
    logic [63:0] addr;
    logic [63:0] last;
    logic [63:0] idx;
    int unsigned cnt;
    reply = '0;
    cnt = managed_blocks();
    if (item.command == CMD_ALLOC) begin
      step = (round_q == 0) ? 64'd1 : 64'(round_q);
      rounded = (64'(item.request_size) + step - 64'd1) & ~(step - 64'd1);
      need = (item.alignment == 0) ? 64'd1 : 64'(item.alignment);
      if (rounded != 64'(block_bytes_q)) begin
        reply.status = ST_WRONG_SIZE;
      end else if (free_top >= NIL) begin
        reply.status = ST_EMPTY;
      end else begin
        addr = (64'(pool_base_q) + 64'(free_top) * 64'(block_bytes_q)) & WRAP_MASK;
        if ((addr & (need - 64'd1)) != 0) begin
          reply.status = ST_MISALIGNED;
        end else begin
          reply.status       = ST_OK;
          reply.address      = addr[FIELD_AW-1:0];
          reply.granted_size = block_bytes_q;
          free_top           = next_free[free_top[LINK_AW-1:0]];
        end
      end
    end else begin
      // Ownership is checked on the unwrapped range of the pool.
      last = 64'(pool_base_q) + 64'(cnt - 1) * 64'(block_bytes_q);
      if (item.request_size != block_bytes_q) begin
        reply.status = ST_WRONG_SIZE;
      end else if (item.block_address < pool_base_q || 64'(item.block_address) > last) begin
        reply.status = ST_NOT_OWNED;
      end else begin
        idx = (block_bytes_q == 0) ? 64'd0 :
              64'(item.block_address - pool_base_q) / 64'(block_bytes_q);
        if (idx >= cnt) idx = cnt - 1;
        next_free[idx[LINK_AW-1:0]] = free_top;
        free_top = IDX_W'(idx);
        reply.status = ST_OK;
      end
    end
    return reply;
  endfunction

  function automatic fbpa_req_t make_req(input logic cmd, input logic [SIZE_W-1:0] size,
                                         input logic [ALIGN_W-1:0] align,
                                         input logic [FIELD_AW-1:0] addr);
    fbpa_req_t item;
    item.command       = cmd;
    item.request_size  = size;
    item.alignment     = align;
    item.block_address = addr;
    return item;
  endfunction

  // Mostly well-formed allocates and frees of held blocks, the rest noise and bad frees.
  function automatic fbpa_req_t random_request();
    fbpa_req_t   item;
    logic [63:0] step;
    logic [63:0] last;
    int unsigned pick;
    int unsigned slot;
    int unsigned slack;
    item = make_req(CMD_ALLOC, '0, ALIGN_W'(1), FIELD_AW'({$urandom, $urandom}));
    step = (round_q == 0) ? 64'd1 : 64'(round_q);
    last = 64'(pool_base_q) + 64'(managed_blocks() - 1) * 64'(block_bytes_q);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // A size that rounds up to the block size whenever the settings allow it.
      slack = (step - 64'd1 < 64'(block_bytes_q)) ? int'(step - 64'd1) : block_bytes_q;
      item.request_size = block_bytes_q - SIZE_W'($urandom_range(0, slack));
      case ($urandom_range(0, 9))
        0: item.alignment = '0;
        1: item.alignment = ALIGN_W'($urandom);
        2, 3, 4: item.alignment = ALIGN_W'(1) << $urandom_range(0, 12);
        default: item.alignment = ALIGN_W'(1);
      endcase
    end else if (pick < 80) begin
      item.command      = CMD_FREE;
      item.request_size = block_bytes_q;
      item.alignment    = ALIGN_W'($urandom);
      if (held_blocks.size() != 0) begin
        slot = $urandom_range(0, held_blocks.size() - 1);
        item.block_address = held_blocks[slot];
        // Now and then the block stays listed, so that it is later freed twice.
        if ($urandom_range(0, 7) != 0) held_blocks.delete(slot);
        if ($urandom_range(0, 5) == 0 && block_bytes_q > 1)
          item.block_address += FIELD_AW'($urandom_range(0, block_bytes_q - 1));
      end else begin
        item.block_address = pool_base_q;
      end
    end else begin
      case ($urandom_range(0, 3))
        0: item = make_req(1'($urandom), $urandom, ALIGN_W'($urandom),
                           FIELD_AW'({$urandom, $urandom}));
        1: item = make_req(CMD_FREE, block_bytes_q, '0, pool_base_q - 1'b1);
        2: item = make_req(CMD_FREE, block_bytes_q, '1, FIELD_AW'(last + 64'd1));
        default: begin
          item.command      = 1'($urandom);
          item.request_size = $urandom_range(0, 1) ? block_bytes_q + 1'b1 : block_bytes_q - 1'b1;
          item.block_address = pool_base_q;
        end
      endcase
    end
    return item;
  endfunction

  // Offers one request in the sender's burst pattern and records its expected response.
  task automatic send_request(input fbpa_req_t item);
    fbpa_rsp_t reply;
    @(negedge clk);
    if (!steady_sender && burst_left == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    req_ch.valid = 1'b1;
    req_ch.data  = item;
    do @(posedge clk); while (!req_ch.ready);
    reply = serve_request(item);
    pending_replies.push_back(reply);
    if (item.command == CMD_ALLOC && reply.status == ST_OK)
      held_blocks.push_back(reply.address);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic idle_request();
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic wait_for_drain();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      REG_POOL_BASE:      pool_base_q = value;
      REG_BLOCK_BYTES:    block_bytes_q = value[SIZE_W-1:0];
      REG_BLOCKS_IN_USE: begin
        count_q = value[COUNT_W-1:0];
        reset_free_list();
      end
      REG_SIZE_ALIGNMENT: round_q = value[ALIGN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Writes all four registers once the pool is idle; the count goes last as it rebuilds the list.
  task automatic configure_pool(input logic [FIELD_AW-1:0] base, input logic [SIZE_W-1:0] blk,
                                input logic [COUNT_W-1:0] count, input logic [ALIGN_W-1:0] rnd);
    idle_request();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_POOL_BASE, base);
    write_reg(REG_BLOCK_BYTES, {16'($urandom), blk});
    write_reg(REG_SIZE_ALIGNMENT, {35'({$urandom, $urandom}), rnd});
    write_reg(REG_BLOCKS_IN_USE, {37'({$urandom, $urandom}), count});
    held_blocks.delete();
  endtask

  // Reset settings: rounding, size limits, alignment, range checks, inner and double frees.
  task automatic test_default_pool();
    send_request(make_req(CMD_ALLOC, 32'd64, 13'd1, '0));
    send_request(make_req(CMD_ALLOC, 32'd1, 13'd0, '0));
    send_request(make_req(CMD_ALLOC, 32'd0, 13'd1, '0));
    send_request(make_req(CMD_ALLOC, 32'd65, 13'd1, '0));
    send_request(make_req(CMD_ALLOC, 32'hFFFF_FFFF, 13'd4096, '0));
    send_request(make_req(CMD_ALLOC, 32'd64, 13'd4096, '0));
    send_request(make_req(CMD_ALLOC, 32'd64, 13'd128, '1));
    send_request(make_req(CMD_ALLOC, 32'd33, 13'h1FFF, '0));
    send_request(make_req(CMD_FREE, 32'd64, 13'd1, 48'd64));
    send_request(make_req(CMD_FREE, 32'd63, 13'h1FFF, 48'd0));
    send_request(make_req(CMD_FREE, 32'd64, 13'd1, 48'd65536));
    send_request(make_req(CMD_FREE, 32'd64, 13'd1, 48'd65472));
    send_request(make_req(CMD_FREE, 32'd64, 13'd1, 48'd70));
    send_request(make_req(CMD_FREE, 32'hFFFF_FFFF, 13'd1, '1));
    send_request(make_req(CMD_ALLOC, 32'd64, 13'd64, '0));
    send_request(make_req(CMD_ALLOC, 32'd64, 13'd64, '0));
  endtask

  // A three-block pool run dry, with frees just outside both ends of its range.
  task automatic test_pool_exhaustion();
    configure_pool(48'h1000, 32'd48, 11'd3, 13'd16);
    repeat (4) send_request(make_req(CMD_ALLOC, 32'd40, 13'd16, '0));
    send_request(make_req(CMD_ALLOC, 32'd49, 13'd1, '0));
    send_request(make_req(CMD_FREE, 32'd48, 13'd1, 48'h0FFF));
    send_request(make_req(CMD_FREE, 32'd48, 13'd1, 48'h1061));
    send_request(make_req(CMD_FREE, 32'd48, 13'd1, 48'h1060));
    send_request(make_req(CMD_ALLOC, 32'd48, 13'd32, '0));
  endtask

  // Random traffic over a series of pool settings, the extremes among them.
  task automatic test_random_phases();
    logic [FIELD_AW-1:0] base;
    int unsigned         k;
    for (int p = 0; p < 10; p++) begin
      base = FIELD_AW'({$urandom, $urandom});
      k = $urandom_range(0, 12);
      case (p)
        0: configure_pool('0, 32'd64, 11'd8, 13'd64);
        1: configure_pool('1, 32'hFFFF_FFFF, 11'd1024, 13'd1);
        2: configure_pool(base & ~48'd63, 32'd0, 11'd5, 13'd0);
        3: configure_pool(base, 32'd4096, 11'd0, 13'd4096);
        4: configure_pool(base, 32'd8192, 11'd2047, 13'h1FFF);
        5: configure_pool(base & ~48'd4095, 32'd48, 11'd3, 13'd16);
        8: configure_pool(48'h1000, 32'd24, 11'd16, 13'd24);
        9: configure_pool(base & ~48'd63, 32'd64, COUNT_W'($urandom_range(1, 1024)), 13'd64);
        default: configure_pool(base & ~((FIELD_AW'(1) << k) - 1'b1),
                                SIZE_W'($urandom_range(1, 64)) << k,
                                COUNT_W'($urandom_range(1, 32)), ALIGN_W'(1) << k);
      endcase
      // The last phase runs without sender gaps.
      steady_sender = (p == 9);
      repeat (100) send_request(random_request());
    end
    steady_sender = 1'b0;
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so the core fills up.
  task automatic test_output_backpressure();
    configure_pool('0, 32'd64, 11'd1024, 13'd64);
    // The hold starts once the free list rebuild is over and requests are taken.
    wait (req_ch.ready === 1'b1);
    steady_sender = 1'b1;
    rsp_hold = 400;
    repeat (40) send_request(random_request());
    steady_sender = 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: runs of stalls and of readiness, or a long hold when one is asked for.
  initial begin
    int unsigned run_left;
    bit          level;
    run_left = 0;
    level = 1'b1;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rsp_hold > 0) begin
        rsp_ch.ready = 1'b0;
        rsp_hold--;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(0, 9))
            0: begin
              level = 1'b1;
              run_left = 100;
            end
            1, 2, 3: begin
              level = 1'b0;
              run_left = $urandom_range(1, 20);
            end
            default: begin
              level = 1'b1;
              run_left = $urandom_range(1, 8);
            end
          endcase
        end
        rsp_ch.ready = level;
        run_left--;
      end
    end
  end

  // Each accepted response is compared with the oldest expected one.
  initial begin
    fbpa_rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
        if (pending_replies.size() == 0) begin
          $error("Response with no request outstanding: status %0d", rsp_ch.data.status);
          error_count++;
        end else begin
          want = pending_replies.pop_front();
          check_field("status", 64'(want.status), 64'(rsp_ch.data.status));
          check_field("address", 64'(want.address), 64'(rsp_ch.data.address));
          check_field("granted_size", 64'(want.granted_size), 64'(rsp_ch.data.granted_size));
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Reset, the tests in turn, then the final drain and verdict.
  initial begin
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    req_ch.valid  = 1'b0;
    req_ch.data   = '0;
    error_count   = 0;
    burst_left    = 0;
    steady_sender = 1'b0;
    rsp_hold      = 0;
    pool_base_q   = POOL_BASE_RST;
    block_bytes_q = BLOCK_BYTES_RST;
    count_q       = BLOCKS_IN_USE_RST;
    round_q       = SIZE_ALIGNMENT_RST;
    reset_free_list();
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_pool();
    test_pool_exhaustion();
    test_random_phases();
    test_output_backpressure();

    idle_request();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
rtl/fbpa_pkg.sv
rtl/fbpa_req_if.sv
rtl/fbpa_rsp_if.sv
rtl/fbpa_ram.sv
rtl/fbpa_shift_alu.sv
rtl/fixed_block_pool_allocator_core.sv
rtl/fbpa_checker.sv
bench/fixed_block_pool_allocator_core_test.sv
